// ----- src/tpps_pkg.sv -----
// ----------------------------------------------------------------------------
// tpps_pkg: shared types and constants for the prescaler/period search
// widths of the stream fields, register indexes and controller interface
// ----------------------------------------------------------------------------
package tpps_pkg;

   localparam int FREQ_W      = 32;
   localparam int CLK_W       = 32;
   localparam int DIV_W       = 16;
   localparam int DIVP1_W     = DIV_W + 1;
   localparam int PSC_W       = 16;
   localparam int PER_W       = 32;
   localparam int STEP_W      = DIVP1_W + FREQ_W;
   localparam int PROD_W      = 64;
   localparam int QUO_W       = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam logic [CLK_W-1:0] TIMER_CLK_RESET = CLK_W'(84000000);
   localparam int PRESCALER_LIMIT_DEFAULT = 65535;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_CLK     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_DIVIDER = CSR_INDEX_W'(1);

   typedef struct packed {
      logic load;        // latch a new frequency, clear results
      logic mul;         // form divp1 * frequency
      logic div_first;   // start clock / frequency
      logic div_prod;    // start clock / product
      logic take_q;      // capture the quotient into the period
      logic advance;     // prescaler + 1, product + step
      logic clear_per;   // product above clock, period is zero
      logic publish;     // load the result register
   } tpps_cmd_type;

   typedef struct packed {
      logic freq_zero;
      logic div_done;
      logic per_over;    // period above 0xffff
      logic psc_below;   // prescaler below its limit
      logic prod_over;   // product above clock
      logic out_free;    // result register can take a beat
   } tpps_status_type;

endpackage

// ----- src/timer_prescaler_period_search.sv -----
// ----------------------------------------------------------------------------
// timer_prescaler_period_search: timer prescaler and period from a frequency
// a zero frequency skips the divider; otherwise a first division, then one
// divider pass per prescaler step, up to the chosen prescaler
// one item at a time: a new request is taken only after the result is published
// reset: synchronous, clears control and loads timer clock 84000000, divider 0
// ----------------------------------------------------------------------------
module timer_prescaler_period_search #(
   parameter int PRESCALER_LIMIT = tpps_pkg::PRESCALER_LIMIT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tpps_pkg::REQ_TDATA_W-1:0] req_tdata,   // [31:0] target_frequency
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tpps_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [15:0] prescaler_value,
                                                         // [47:16] period_value
   output logic [0:0]                       rsp_tuser,   // [0] zero_frequency
   // register write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tpps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tpps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tpps_pkg::*;

   tpps_cmd_type    cmd;
   tpps_status_type status;
   logic [PSC_W-1:0] prescaler_value;
   logic [PER_W-1:0] period_value;
   logic             zero_frequency;

   // registers are always writable; the user must write them only while idle, the block itself does not enforce it
   assign csr_ready = 1'b1;

   // controller: one item at a time, loops while the period is too large
   tpps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // datapath: product grows by divp1*freq per prescaler step,
   // a shared divider forms clock / product
   tpps_dp #(
      .PRESCALER_LIMIT (PRESCALER_LIMIT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .target_frequency (req_tdata[FREQ_W-1:0]),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .prescaler_value  (prescaler_value),
      .period_value     (period_value),
      .zero_frequency   (zero_frequency)
   );

   // pack the response beat, prescaler in the low bits
   assign rsp_tdata    = {period_value, prescaler_value};
   assign rsp_tuser[0] = zero_frequency;

   // a zero frequency beat carries all-zero results
   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("zero frequency beat with nonzero results");

   // a period above 16 bits only when the prescaler hit its limit
   a_period_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_TDATA_W-1:PSC_W+16] != '0)
      |-> rsp_tdata[PSC_W-1:0] == PSC_W'(PRESCALER_LIMIT))
      else $error("large period with prescaler below its limit");

   // the search takes one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a search is running");

endmodule

// ----- src/tpps_div.sv -----
// ----------------------------------------------------------------------------
// tpps_div: restoring divider
// one quotient bit per cycle, done pulses when the quotient is final
// ----------------------------------------------------------------------------
module tpps_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tpps_pkg::QUO_W-1:0] dividend,
   input  logic [tpps_pkg::QUO_W-1:0] divisor,
   output logic [tpps_pkg::QUO_W-1:0] quotient,
   output logic                      done
);
   import tpps_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   logic [QUO_W-1:0] acc_ff, acc_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [QUO_W-1:0] dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [QUO_W:0]   shifted;
   logic [QUO_W+1:0] diff;
   logic             ge;

   always_comb begin
      shifted = {acc_ff, quo_ff[QUO_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      ge      = ~diff[QUO_W+1];
      acc_in  = ge ? diff[QUO_W-1:0] : shifted[QUO_W-1:0];
      quo_in  = {quo_ff[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
         cnt_ff <= CNT_W'(QUO_W - 1);
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- src/tpps_dp.sv -----
// ----------------------------------------------------------------------------
// tpps_dp: datapath of the prescaler/period search
// config registers, product accumulator, divider and result register
// ----------------------------------------------------------------------------
module tpps_dp #(
   parameter int PRESCALER_LIMIT = tpps_pkg::PRESCALER_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tpps_pkg::tpps_cmd_type          cmd,
   output tpps_pkg::tpps_status_type       status,
   input  logic [tpps_pkg::FREQ_W-1:0]     target_frequency,
   input  logic                            csr_write,
   input  logic [tpps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tpps_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [tpps_pkg::PSC_W-1:0]      prescaler_value,
   output logic [tpps_pkg::PER_W-1:0]      period_value,
   output logic                            zero_frequency
);
   import tpps_pkg::*;

   logic [CLK_W-1:0]  timer_clk_ff;
   logic [DIV_W-1:0]  clock_div_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic              zero_ff;
   logic [PSC_W-1:0]  psc_ff;
   logic [PER_W-1:0]  per_ff;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [PROD_W-1:0] prod_ff;
   logic              minus_one_ff;
   logic [QUO_W-1:0]  quotient;
   logic              div_done;
   logic [QUO_W-1:0]  divisor;
   logic [PER_W-1:0]  q_adj;

   logic              rsp_valid_ff;
   logic [PSC_W-1:0]  rsp_psc_ff;
   logic [PER_W-1:0]  rsp_per_ff;
   logic              rsp_zero_ff;

   // config registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clk_ff <= TIMER_CLK_RESET;
         clock_div_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TIMER_CLK:     timer_clk_ff <= csr_data[CLK_W-1:0];
            CSR_CLOCK_DIVIDER: clock_div_ff <= csr_data[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   assign step_in = STEP_W'({1'b0, clock_div_ff} + DIVP1_W'(1)) * STEP_W'(freq_ff);
   assign divisor = cmd.div_first ? freq_ff : prod_ff[QUO_W-1:0];
   // saturating minus one on the quotient of the product
   assign q_adj   = minus_one_ff ? ((quotient == '0) ? '0 : quotient - QUO_W'(1)) : quotient;

   tpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_first | cmd.div_prod),
      .dividend (timer_clk_ff),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         freq_ff <= target_frequency;
         zero_ff <= (target_frequency == '0);
         psc_ff  <= '0;
         per_ff  <= '0;
      end
      if (cmd.mul) begin
         step_ff <= step_in;
         prod_ff <= PROD_W'(step_in);
      end
      if (cmd.div_first) minus_one_ff <= 1'b0;
      if (cmd.div_prod)  minus_one_ff <= 1'b1;
      if (cmd.take_q)    per_ff <= q_adj;
      if (cmd.clear_per) per_ff <= '0;
      if (cmd.advance) begin
         psc_ff  <= psc_ff + PSC_W'(1);
         prod_ff <= prod_ff + PROD_W'(step_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_psc_ff  <= psc_ff;
         rsp_per_ff  <= per_ff;
         rsp_zero_ff <= zero_ff;
      end
   end

   always_comb begin
      status.freq_zero = zero_ff;
      status.div_done  = div_done;
      status.per_over  = (per_ff[PER_W-1:16] != '0);
      status.psc_below = (psc_ff < PSC_W'(PRESCALER_LIMIT));
      status.prod_over = (prod_ff > PROD_W'(timer_clk_ff));
      status.out_free  = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign prescaler_value = rsp_psc_ff;
   assign period_value    = rsp_per_ff;
   assign zero_frequency  = rsp_zero_ff;

endmodule

// ----- src/tpps_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpps_ctrl: controller of the prescaler/period search
// sequences first division, prescaler steps and result hand-off
// ----------------------------------------------------------------------------
module tpps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   output tpps_pkg::tpps_cmd_type    cmd,
   input  tpps_pkg::tpps_status_type status
);
   import tpps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WAIT,
      ST_CHECK,
      ST_PROD,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (status.freq_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_first = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (status.div_done) begin
               cmd.take_q = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.per_over && status.psc_below) begin
               cmd.advance = 1'b1;
               state_in    = ST_PROD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PROD: begin
            if (status.prod_over) begin
               cmd.clear_per = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               cmd.div_prod = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule
